[rtl/core/rcg_pkg.sv]
package rcg_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_PULSE   = 3'd0,
		REG_MAX_PULSE   = 3'd1,
		REG_THRESH_FRAC = 3'd2,
		REG_OPEN_PULSES = 3'd3,
		REG_OPEN_AMP    = 3'd4,
		REG_SETTLE      = 3'd5,
		REG_FLAT_RATIO  = 3'd6
	} cfg_reg_t;

	localparam logic [7:0]  RST_MIN_PULSE   = 8'd6;
	localparam logic [7:0]  RST_MAX_PULSE   = 8'd100;
	localparam logic [7:0]  RST_THRESH_FRAC = 8'd192;
	localparam logic [5:0]  RST_OPEN_PULSES = 6'd16;
	localparam logic [15:0] RST_OPEN_AMP    = 16'd20000;
	localparam logic [9:0]  RST_SETTLE      = 10'd100;
	localparam logic [15:0] RST_FLAT_RATIO  = 16'd328;

	localparam logic [7:0]  EDGE_CNT_MAX  = 8'd255;
	localparam logic [5:0]  PULSE_CNT_MAX = 6'd63;
	localparam logic [10:0] PASS_CNT_MAX  = 11'd2047;

	typedef struct packed {
		logic signed [15:0] sample_i;
		logic signed [15:0] sample_q;
	} sample_t;

	typedef struct packed {
		logic               out_valid;
		logic signed [15:0] out_i;
		logic signed [15:0] out_q;
		logic               gate_is_open;
		logic               gate_just_opened;
		logic               gate_closed_flat;
		logic               trigger_request;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQI,
		ST_SQQ,
		ST_ROOT,
		ST_UPD,
		ST_MSQ,
		ST_CMP,
		ST_DEC,
		ST_FLAT_SS,
		ST_FLAT_NQ,
		ST_FLAT_FS,
		ST_FLAT_FF,
		ST_FLAT_DEC,
		ST_EMIT
	} state_t;

endpackage

[rtl/core/rcg_isqrt.sv]
// floor square root of a 32-bit value, one result bit a cycle
module rcg_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] value,
	output logic        done,
	output logic [15:0] root
);

	logic [31:0] rem_q;
	logic [31:0] res_q;
	logic [3:0]  k_q;
	logic        run_q;
	logic        done_q;
	logic [31:0] bit_w;
	logic [31:0] trial;

	assign bit_w = 32'd1 << {k_q, 1'b0};
	assign trial = res_q + bit_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				k_q   <= 4'd15;
			end else if (run_q) begin
				k_q <= k_q - 4'd1;
				if (k_q == 4'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= value;
			res_q <= '0;
		end else if (run_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_w;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

	assign done = done_q;
	assign root = res_q[15:0];

endmodule

[rtl/core/rcg_mul.sv]
// shift-and-add multiplier, one multiplier bit a cycle
module rcg_mul #(
	parameter int W = 41
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic           done,
	output logic [2*W-1:0] p
);

	localparam int CW = $clog2(W + 1);

	logic [2*W-1:0] acc_q;
	logic [2*W-1:0] ash_q;
	logic [W-1:0]   bsh_q;
	logic [CW-1:0]  cnt_q;
	logic           run_q;
	logic           done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			ash_q <= (2*W)'(a);
			bsh_q <= b;
		end else if (run_q) begin
			if (bsh_q[0]) begin
				acc_q <= acc_q + ash_q;
			end
			ash_q <= ash_q << 1;
			bsh_q <= bsh_q >> 1;
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

[rtl/core/reader_command_gate_unit.sv]
// channel   dir  handshake                     payload
// sample    in   sample_valid / sample_stall   rcg_pkg::sample_t (sample_i, sample_q)
// result    out  result_valid / result_stall   rcg_pkg::result_t (one per sample)
// config    in   cfg_we, cfg_index, cfg_data   7 registers, write only
//
// a sample is taken only in idle and runs to its result before the next is taken, through the 16 steps
// of the root unit, the window memory read-modify-write and the edge and gate decisions
// a sample that ends a block also runs the four products of the flatness test,
// one after another on the serial multiplier
// reset clears the control, configuration and gate state at once; the window memory is masked by a fill flag
// a result waits in its output register, so the next sample is taken while it is stalled
module reader_command_gate_unit #(
	parameter int WINDOW_LEN = 64,
	parameter int BLOCK_LEN  = 300
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  rcg_pkg::sample_t                    sample,
	output logic                                result_valid,
	input  logic                                result_stall,
	output rcg_pkg::result_t                    result,
	input  logic                                cfg_we,
	input  logic [rcg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rcg_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int WIDX = $clog2(WINDOW_LEN);
	localparam int SUMW = 16 + $clog2(WINDOW_LEN + 1);
	localparam int BCW  = $clog2(BLOCK_LEN + 1);
	localparam int BSW  = 16 + BCW;
	localparam int BQW  = 32 + BCW;
	localparam int MW   = 32 + BCW;
	localparam int PW   = 2 * MW;

	rcg_pkg::state_t state_q, state_nxt;

	// configuration registers
	logic [7:0]  min_pulse_q, max_pulse_q, thresh_q;
	logic [5:0]  open_pulses_q;
	logic [15:0] open_amp_q, flat_ratio_q;
	logic [9:0]  settle_q;

	// gate state
	logic             go_q;
	logic [WIDX-1:0]  wpos_q;
	logic             filled_q;
	logic [SUMW-1:0]  wsum_q;
	logic             gate_q, armed_q, trig_q;
	logic [7:0]       esc_q;
	logic [5:0]       pc_q;
	logic [10:0]      pass_q;
	logic [BCW-1:0]   bc_q;
	logic [BSW-1:0]   bsum_q;
	logic [BQW-1:0]   bsq_q;
	logic             valid_q, opened_q, flatc_q;
	logic             result_valid_q;

	// datapath registers
	logic signed [15:0] si_s1, sq_s1;
	logic [31:0]        prod_q, pw_q, msq_q;
	logic [15:0]        mag_q, rd_q;
	logic [SUMW-1:0]    lhs_q, amp_q;
	logic [SUMW+7:0]    rhs_q;
	logic [PW-1:0]      ss_q, d_q;
	logic [MW-1:0]      frs_q;
	rcg_pkg::result_t   result_q;

	logic [15:0] window_mem [WINDOW_LEN];

	logic        accept;
	logic        sq_start, sq_done;
	logic [15:0] root;
	logic        mul_start, mul_done;
	logic [MW-1:0] mul_a, mul_b;
	logic [PW-1:0] mul_p;
	logic [15:0] old_mag;
	logic        emit_ok;

	// decision of one sample
	logic            pos, neg;
	logic            n_armed, n_gate, n_trig, n_valid, n_opened, blk_end;
	logic [7:0]      n_esc;
	logic [5:0]      n_pc;
	logic [10:0]     n_pass;
	logic [BCW-1:0]  n_bc;
	logic [BSW-1:0]  n_bsum;
	logic [BQW-1:0]  n_bsq;
	logic            flat;

	assign accept  = sample_valid && !sample_stall;
	assign sample_stall = (state_q != rcg_pkg::ST_IDLE);
	assign old_mag = filled_q ? rd_q : 16'd0;
	assign emit_ok = !result_valid_q || !result_stall;

	rcg_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (pw_q),
		.done   (sq_done),
		.root   (root)
	);

	rcg_mul #(.W(MW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rcg_pkg::ST_IDLE:     if (sample_valid) state_nxt = rcg_pkg::ST_SQI;
			rcg_pkg::ST_SQI:      state_nxt = rcg_pkg::ST_SQQ;
			rcg_pkg::ST_SQQ:      state_nxt = rcg_pkg::ST_ROOT;
			rcg_pkg::ST_ROOT:     if (sq_done) state_nxt = rcg_pkg::ST_UPD;
			rcg_pkg::ST_UPD:      state_nxt = rcg_pkg::ST_MSQ;
			rcg_pkg::ST_MSQ:      state_nxt = rcg_pkg::ST_CMP;
			rcg_pkg::ST_CMP:      state_nxt = rcg_pkg::ST_DEC;
			rcg_pkg::ST_DEC: begin
				state_nxt = blk_end ? rcg_pkg::ST_FLAT_SS : rcg_pkg::ST_EMIT;
			end
			rcg_pkg::ST_FLAT_SS:  if (mul_done) state_nxt = rcg_pkg::ST_FLAT_NQ;
			rcg_pkg::ST_FLAT_NQ:  if (mul_done) state_nxt = rcg_pkg::ST_FLAT_FS;
			rcg_pkg::ST_FLAT_FS:  if (mul_done) state_nxt = rcg_pkg::ST_FLAT_FF;
			rcg_pkg::ST_FLAT_FF:  if (mul_done) state_nxt = rcg_pkg::ST_FLAT_DEC;
			rcg_pkg::ST_FLAT_DEC: state_nxt = rcg_pkg::ST_EMIT;
			rcg_pkg::ST_EMIT:     if (emit_ok) state_nxt = rcg_pkg::ST_IDLE;
			default:              state_nxt = rcg_pkg::ST_IDLE;
		endcase
	end

	// unit starts and multiplier operands
	always_comb begin
		sq_start  = 1'b0;
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			rcg_pkg::ST_ROOT: sq_start = !go_q;
			rcg_pkg::ST_FLAT_SS: begin
				mul_start = !go_q;
				mul_a     = MW'(bsum_q);
				mul_b     = MW'(bsum_q);
			end
			rcg_pkg::ST_FLAT_NQ: begin
				mul_start = !go_q;
				mul_a     = MW'(bsq_q);
				mul_b     = MW'(BLOCK_LEN);
			end
			rcg_pkg::ST_FLAT_FS: begin
				mul_start = !go_q;
				mul_a     = MW'(flat_ratio_q);
				mul_b     = MW'(bsum_q);
			end
			rcg_pkg::ST_FLAT_FF: begin
				mul_start = !go_q;
				mul_a     = frs_q;
				mul_b     = frs_q;
			end
			default: begin
				sq_start  = 1'b0;
				mul_start = 1'b0;
			end
		endcase
	end

	// edge, pulse and gate decision for the current sample
	always_comb begin
		pos      = {lhs_q, 8'd0} > rhs_q;
		neg      = {lhs_q, 8'd0} < rhs_q;
		n_armed  = armed_q;
		n_gate   = gate_q;
		n_trig   = trig_q;
		n_esc    = esc_q;
		n_pc     = pc_q;
		n_pass   = pass_q;
		n_bc     = bc_q;
		n_bsum   = bsum_q;
		n_bsq    = bsq_q;
		n_valid  = 1'b0;
		n_opened = 1'b0;
		blk_end  = 1'b0;
		if (!gate_q) begin
			n_trig = 1'b1;
			if (n_esc != rcg_pkg::EDGE_CNT_MAX) n_esc = n_esc + 8'd1;
			if (neg && !n_armed) begin
				n_esc   = '0;
				n_armed = 1'b1;
			end
			if (n_armed && pos) begin
				// pulse width must lie strictly between half the minimum and the maximum
				if (n_esc > {1'b0, min_pulse_q[7:1]} && n_esc < max_pulse_q) begin
					if (n_pc != rcg_pkg::PULSE_CNT_MAX) n_pc = n_pc + 6'd1;
					n_armed = 1'b0;
				end else begin
					n_pc = '0;
				end
				n_esc = '0;
			end
			if (pos && n_pc >= open_pulses_q && wsum_q > amp_q) begin
				n_gate   = 1'b1;
				n_opened = 1'b1;
				n_pc     = '0;
				n_esc    = '0;
				n_pass   = '0;
				n_bc     = '0;
				n_bsum   = '0;
				n_bsq    = '0;
				n_trig   = 1'b0;
			end
		end
		if (n_gate) begin
			if (n_pass != rcg_pkg::PASS_CNT_MAX) n_pass = n_pass + 11'd1;
			if (n_pass > {1'b0, settle_q}) begin
				n_valid = 1'b1;
				n_bsum  = n_bsum + BSW'(mag_q);
				n_bsq   = n_bsq + BQW'(msq_q);
				n_bc    = n_bc + BCW'(1);
				blk_end = (n_bc >= BCW'(BLOCK_LEN));
			end
		end
	end

	// flatness: (n*Q - S*S) * 2^32 < (ratio*S)^2, never for an all-zero block
	assign flat = (bsum_q != '0) && ({d_q, 32'd0} < {32'd0, mul_p});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= rcg_pkg::ST_IDLE;
			go_q           <= 1'b0;
			min_pulse_q    <= rcg_pkg::RST_MIN_PULSE;
			max_pulse_q    <= rcg_pkg::RST_MAX_PULSE;
			thresh_q       <= rcg_pkg::RST_THRESH_FRAC;
			open_pulses_q  <= rcg_pkg::RST_OPEN_PULSES;
			open_amp_q     <= rcg_pkg::RST_OPEN_AMP;
			settle_q       <= rcg_pkg::RST_SETTLE;
			flat_ratio_q   <= rcg_pkg::RST_FLAT_RATIO;
			wpos_q         <= '0;
			filled_q       <= 1'b0;
			wsum_q         <= '0;
			gate_q         <= 1'b0;
			armed_q        <= 1'b0;
			trig_q         <= 1'b0;
			esc_q          <= '0;
			pc_q           <= '0;
			pass_q         <= '0;
			bc_q           <= '0;
			bsum_q         <= '0;
			bsq_q          <= '0;
			valid_q        <= 1'b0;
			opened_q       <= 1'b0;
			flatc_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;

			if (sq_start || mul_start) begin
				go_q <= 1'b1;
			end else if (sq_done || mul_done) begin
				go_q <= 1'b0;
			end

			if (cfg_we) begin
				case (rcg_pkg::cfg_reg_t'(cfg_index))
					rcg_pkg::REG_MIN_PULSE:   min_pulse_q   <= cfg_data[7:0];
					rcg_pkg::REG_MAX_PULSE:   max_pulse_q   <= cfg_data[7:0];
					rcg_pkg::REG_THRESH_FRAC: thresh_q      <= cfg_data[7:0];
					rcg_pkg::REG_OPEN_PULSES: open_pulses_q <= cfg_data[5:0];
					rcg_pkg::REG_OPEN_AMP:    open_amp_q    <= cfg_data;
					rcg_pkg::REG_SETTLE:      settle_q      <= cfg_data[9:0];
					rcg_pkg::REG_FLAT_RATIO:  flat_ratio_q  <= cfg_data;
					default: ;
				endcase
			end

			// window sum: drop the oldest magnitude, add the new one
			if (state_q == rcg_pkg::ST_UPD) begin
				wsum_q <= wsum_q - SUMW'(old_mag) + SUMW'(mag_q);
				if (wpos_q == WIDX'(WINDOW_LEN - 1)) begin
					wpos_q   <= '0;
					filled_q <= 1'b1;
				end else begin
					wpos_q <= wpos_q + WIDX'(1);
				end
			end

			if (state_q == rcg_pkg::ST_DEC) begin
				armed_q  <= n_armed;
				gate_q   <= n_gate;
				trig_q   <= n_trig;
				esc_q    <= n_esc;
				pc_q     <= n_pc;
				pass_q   <= n_pass;
				bc_q     <= n_bc;
				bsum_q   <= n_bsum;
				bsq_q    <= n_bsq;
				valid_q  <= n_valid;
				opened_q <= n_opened;
				flatc_q  <= 1'b0;
			end

			if (state_q == rcg_pkg::ST_FLAT_DEC) begin
				if (flat) begin
					gate_q  <= 1'b0;
					trig_q  <= 1'b1;
					flatc_q <= 1'b1;
					pc_q    <= '0;
					esc_q   <= '0;
				end else begin
					trig_q <= 1'b0;
				end
				bc_q   <= '0;
				bsum_q <= '0;
				bsq_q  <= '0;
			end

			if (state_q == rcg_pkg::ST_EMIT && emit_ok) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// window memory, read at acceptance and written back once the root is known
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= window_mem[wpos_q];
		end
		if (state_q == rcg_pkg::ST_UPD) begin
			window_mem[wpos_q] <= mag_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			si_s1 <= sample.sample_i;
			sq_s1 <= sample.sample_q;
		end
		case (state_q)
			rcg_pkg::ST_SQI: prod_q <= 32'(si_s1 * si_s1);
			rcg_pkg::ST_SQQ: pw_q   <= prod_q + 32'(sq_s1 * sq_s1);
			rcg_pkg::ST_ROOT: begin
				amp_q <= SUMW'(open_amp_q) * SUMW'(WINDOW_LEN);
				if (sq_done) mag_q <= root;
			end
			rcg_pkg::ST_UPD: lhs_q <= SUMW'(mag_q) * SUMW'(WINDOW_LEN);
			rcg_pkg::ST_MSQ: msq_q <= 32'(mag_q) * 32'(mag_q);
			rcg_pkg::ST_CMP: rhs_q <= (SUMW+8)'(wsum_q) * (SUMW+8)'(thresh_q);
			rcg_pkg::ST_FLAT_SS: if (mul_done) ss_q <= mul_p;
			rcg_pkg::ST_FLAT_NQ: begin
				if (mul_done) d_q <= (mul_p >= ss_q) ? (mul_p - ss_q) : '0;
			end
			rcg_pkg::ST_FLAT_FS: if (mul_done) frs_q <= mul_p[MW-1:0];
			rcg_pkg::ST_EMIT: begin
				if (emit_ok) begin
					result_q.out_valid        <= valid_q;
					result_q.out_i            <= valid_q ? si_s1 : 16'sd0;
					result_q.out_q            <= valid_q ? sq_s1 : 16'sd0;
					result_q.gate_is_open     <= gate_q;
					result_q.gate_just_opened <= opened_q;
					result_q.gate_closed_flat <= flatc_q;
					result_q.trigger_request  <= trig_q;
				end
			end
			default: ;
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// a freshly opened gate is still open on that sample
	a_open_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.gate_just_opened) |-> result.gate_is_open)
		else $error("opened gate reported closed");

	// a flat close leaves the gate closed and the trigger raised
	a_flat_close: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.gate_closed_flat) |->
		(!result.gate_is_open && result.trigger_request && result.out_valid))
		else $error("flat close inconsistent");

	// a dropped sample carries zero payload
	a_zero_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.out_valid) |-> (result.out_i == 16'sd0 && result.out_q == 16'sd0))
		else $error("dropped sample not zeroed");

	// one sample in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> sample_stall)
		else $error("second transaction taken while busy");

	// the root unit and the multiplier never run together
	a_unit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(sq_start && mul_start))
		else $error("both arithmetic units started");

endmodule
